// ===== sv/kwl_pkg.sv =====
// kwl_pkg: shared types, constants and helpers for the keyword token lexer
`timescale 1ns / 1ps

package kwl_pkg;

  // fixed field widths of the channels
  localparam int OUT_W  = 16;
  localparam int TYPE_W = 4;
  localparam int CHAR_W = 8;

  // defaults for the top-level parameters
  localparam int POSITION_BITS_DEF = 16;
  localparam int PREFIX_CHARS_DEF  = 6;

  // token classes
  typedef enum logic [TYPE_W-1:0] {
    TOK_LET        = 4'd0,
    TOK_DEF        = 4'd1,
    TOK_MAIN       = 4'd2,
    TOK_PRINT      = 4'd3,
    TOK_ARROW      = 4'd4,
    TOK_EQUALS     = 4'd5,
    TOK_PLUS       = 4'd6,
    TOK_MINUS      = 4'd7,
    TOK_MULTIPLY   = 4'd8,
    TOK_HEX        = 4'd9,
    TOK_PARAM      = 4'd10,
    TOK_COMMENT    = 4'd11,
    TOK_IDENTIFIER = 4'd12
  } tok_type_t;

  // input item modes
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_EOL  = 1'b1;

  // keywords and marker characters
  localparam logic [23:0] KW_LET   = "let";
  localparam logic [23:0] KW_DEF   = "def";
  localparam logic [31:0] KW_MAIN  = "main";
  localparam logic [39:0] KW_PRINT = "print";
  localparam logic [15:0] KW_ARROW = "=>";
  localparam logic [15:0] KW_HEX   = "0x";
  localparam logic [7:0]  CH_EQ    = "=";
  localparam logic [7:0]  CH_PLUS  = "+";
  localparam logic [7:0]  CH_MINUS = "-";
  localparam logic [7:0]  CH_STAR  = "*";
  localparam logic [7:0]  CH_UNDER = "_";
  localparam logic [7:0]  CH_SLASH = "/";
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_CR    = 8'h0D;

  // blank, tab and the vertical control characters up to carriage return
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== sv/kwl_if.sv =====
// kwl_in_if and kwl_out_if: character and token channels
`timescale 1ns / 1ps

interface kwl_in_if import kwl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output mode, output ch, input ready);
  modport sink   (input valid, input mode, input ch, output ready);
endinterface

interface kwl_out_if import kwl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] tok_class;
  logic [OUT_W-1:0]  line_index;
  logic [OUT_W-1:0]  column;
  logic [OUT_W-1:0]  token_length;
  logic              last;

  modport source (output valid, output tok_class, output line_index, output column,
                  output token_length, output last, input ready);
  modport sink   (input valid, input tok_class, input line_index, input column,
                  input token_length, input last, output ready);
endinterface

// ===== sv/kwl_classify.sv =====
// kwl_classify: token class from the kept prefix and the full token length
`timescale 1ns / 1ps

module kwl_classify import kwl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int PREFIX_CHARS  = PREFIX_CHARS_DEF
) (
  input  logic [PREFIX_CHARS-1:0][CHAR_W-1:0] prefix,
  input  logic [POSITION_BITS-1:0]            len,
  output tok_type_t                           tok_class
);

  logic len1, len2, len3, len4, len5;

  // length decode for the exact matches
  assign len1 = (len == POSITION_BITS'(1));
  assign len2 = (len == POSITION_BITS'(2));
  assign len3 = (len == POSITION_BITS'(3));
  assign len4 = (len == POSITION_BITS'(4));
  assign len5 = (len == POSITION_BITS'(5));

  // keywords first, then operators, then prefix classes
  always_comb begin
    priority if (len3 && ({prefix[0], prefix[1], prefix[2]} == KW_LET)) begin
      tok_class = TOK_LET;
    end else if (len3 && ({prefix[0], prefix[1], prefix[2]} == KW_DEF)) begin
      tok_class = TOK_DEF;
    end else if (len4 && ({prefix[0], prefix[1], prefix[2], prefix[3]} == KW_MAIN)) begin
      tok_class = TOK_MAIN;
    end else if (len5 &&
                 ({prefix[0], prefix[1], prefix[2], prefix[3], prefix[4]} == KW_PRINT)) begin
      tok_class = TOK_PRINT;
    end else if (len2 && ({prefix[0], prefix[1]} == KW_ARROW)) begin
      tok_class = TOK_ARROW;
    end else if (len1 && (prefix[0] == CH_EQ)) begin
      tok_class = TOK_EQUALS;
    end else if (len1 && (prefix[0] == CH_PLUS)) begin
      tok_class = TOK_PLUS;
    end else if (len1 && (prefix[0] == CH_MINUS)) begin
      tok_class = TOK_MINUS;
    end else if (len1 && (prefix[0] == CH_STAR)) begin
      tok_class = TOK_MULTIPLY;
    end else if ((len >= POSITION_BITS'(2)) && ({prefix[0], prefix[1]} == KW_HEX)) begin
      tok_class = TOK_HEX;
    end else if ((len != '0) && (prefix[0] == CH_UNDER)) begin
      tok_class = TOK_PARAM;
    end else begin
      tok_class = TOK_IDENTIFIER;
    end
  end

endmodule

// ===== sv/keyword_token_lexer_unit.sv =====
// keyword_token_lexer_unit: splits a character stream into classified tokens
//
//   channel  | dir | payload                                           | transfer
//   chars    | in  | mode, ch                                          | valid & ready
//   tokens   | out | tok_class, line_index, column, token_length, last | valid & ready
//
// One character or end-of-line item per cycle while the token output does not stall;
// each item gives zero or one token, since a comment has always closed the code token
// of its line before end of line. An item's token passes from the input register into
// the result register, where it is held until it is taken.
// Reset clears all line state, the line counter and both registers' valid bits.
// A stalled result holds in the result register while one more item waits in
// the input register; a third item is refused until the result is taken.
`timescale 1ns / 1ps

module keyword_token_lexer_unit import kwl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int PREFIX_CHARS  = PREFIX_CHARS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  kwl_in_if.sink    chars,
  kwl_out_if.source tokens
);

  localparam int PB    = POSITION_BITS;
  localparam int IDX_W = $clog2(PREFIX_CHARS);

  typedef logic [PREFIX_CHARS-1:0][CHAR_W-1:0] prefix_t;

  // helpers: saturating add and increment, and resizing to the output width
  function automatic logic [PB-1:0] sat_add(input logic [PB-1:0] a, input logic [PB-1:0] b);
    logic [PB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PB] ? '1 : s[PB-1:0];
  endfunction

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] a);
    return sat_add(a, PB'(1));
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [PB-1:0] v);
    logic [OUT_W+PB-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

  // input register
  logic              s1_valid;
  logic              s1_mode;
  logic [CHAR_W-1:0] s1_ch;
  logic              s1_go;
  logic              s1_fire;

  // line state
  prefix_t           prefix;
  logic [PB-1:0]     len;
  logic              pending_slash;
  logic              in_comment;
  logic [PB-1:0]     comment_start;
  logic [PB-1:0]     line_position;
  logic [PB-1:0]     column_sum;
  logic [PB-1:0]     line_counter;

  // result register
  logic              out_valid;
  tok_type_t         out_type;
  logic [OUT_W-1:0]  out_line;
  logic [OUT_W-1:0]  out_column;
  logic [OUT_W-1:0]  out_length;

  // handshake: the input register drains whenever the result slot is free
  assign s1_go       = !out_valid || tokens.ready;
  assign s1_fire     = s1_valid && s1_go;
  assign chars.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_mode <= chars.mode;
      s1_ch   <= chars.ch;
    end
  end

  // item decode
  logic is_eol, is_slash, is_blank;
  logic app_slash, app_char, flush, start_comment, open_slash;

  assign is_eol   = (s1_mode == MODE_EOL);
  assign is_slash = (s1_ch == CH_SLASH);
  assign is_blank = is_space(s1_ch);

  always_comb begin
    app_slash     = 1'b0;
    app_char      = 1'b0;
    flush         = 1'b0;
    start_comment = 1'b0;
    open_slash    = 1'b0;
    priority if (is_eol) begin
      app_slash = pending_slash;
      flush     = 1'b1;
    end else if (in_comment) begin
      // comment text only advances the position
    end else if (pending_slash && is_slash) begin
      start_comment = 1'b1;
      flush         = 1'b1;
    end else begin
      app_slash  = pending_slash;
      open_slash = is_slash;
      flush      = !is_slash && is_blank;
      app_char   = !is_slash && !is_blank;
    end
  end

  // token after the held slash and the new character are appended
  prefix_t       prefix_a, prefix_b;
  logic [PB-1:0] len_a, len_b;

  always_comb begin
    prefix_a = prefix;
    len_a    = len;
    if (app_slash) begin
      if (len < PB'(PREFIX_CHARS)) begin
        prefix_a[len[IDX_W-1:0]] = CH_SLASH;
      end
      len_a = sat_inc(len);
    end
    prefix_b = prefix_a;
    len_b    = len_a;
    if (app_char) begin
      if (len_a < PB'(PREFIX_CHARS)) begin
        prefix_b[len_a[IDX_W-1:0]] = s1_ch;
      end
      len_b = sat_inc(len_a);
    end
  end

  tok_type_t cls_type;

  kwl_classify #(
    .POSITION_BITS(POSITION_BITS),
    .PREFIX_CHARS (PREFIX_CHARS)
  ) u_classify (
    .prefix   (prefix_b),
    .len      (len_b),
    .tok_class(cls_type)
  );

  // result selection: at most one token per item
  logic          emit_code, emit_comment, emit;
  logic [PB-1:0] comment_len;

  assign emit_code    = flush && (len_b != '0);
  assign emit_comment = is_eol && in_comment;
  assign emit         = emit_code || emit_comment;
  assign comment_len  = (line_position >= comment_start) ? (line_position - comment_start)
                                                         : '0;

  // next line state
  prefix_t       prefix_next;
  logic [PB-1:0] len_next;
  logic          pending_slash_next;
  logic          in_comment_next;
  logic [PB-1:0] comment_start_next;
  logic [PB-1:0] line_position_next;
  logic [PB-1:0] column_sum_next;
  logic [PB-1:0] line_counter_next;

  always_comb begin
    prefix_next        = prefix_b;
    len_next           = len_b;
    pending_slash_next = open_slash;
    in_comment_next    = in_comment || start_comment;
    comment_start_next = open_slash ? line_position : comment_start;
    line_position_next = sat_inc(line_position);
    column_sum_next    = column_sum;
    line_counter_next  = line_counter;
    if (flush) begin
      prefix_next = '0;
      len_next    = '0;
      if (emit_code) begin
        column_sum_next = sat_add(column_sum, sat_inc(len_b));
      end
    end
    if (is_eol) begin
      pending_slash_next = 1'b0;
      in_comment_next    = 1'b0;
      comment_start_next = '0;
      line_position_next = '0;
      column_sum_next    = '0;
      line_counter_next  = sat_inc(line_counter);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix        <= '0;
      len           <= '0;
      pending_slash <= 1'b0;
      in_comment    <= 1'b0;
      comment_start <= '0;
      line_position <= '0;
      column_sum    <= '0;
      line_counter  <= '0;
    end else if (s1_fire) begin
      prefix        <= prefix_next;
      len           <= len_next;
      pending_slash <= pending_slash_next;
      in_comment    <= in_comment_next;
      comment_start <= comment_start_next;
      line_position <= line_position_next;
      column_sum    <= column_sum_next;
      line_counter  <= line_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_type   <= emit_code ? cls_type : TOK_COMMENT;
      out_line   <= to_out(line_counter);
      out_column <= to_out(emit_code ? column_sum : comment_start);
      out_length <= to_out(emit_code ? len_b : comment_len);
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.tok_class    = out_type;
  assign tokens.line_index   = out_line;
  assign tokens.column       = out_column;
  assign tokens.token_length = out_length;
  assign tokens.last         = 1'b1;

endmodule

// ===== sv/kwl_checker.sv =====
// kwl_checker: port-level assertions for the lexer, bound to the top level
`timescale 1ns / 1ps

module kwl_checker import kwl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TYPE_W-1:0] tok_class,
  input logic [OUT_W-1:0]  token_length,
  input logic              last
);

  // a stalled token holds its class and length
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tok_class) && $stable(token_length))
    else $error("token changed while stalled");

  // every item yields at most one token, so each token closes its item
  a_last: assert property (@(posedge clk) disable iff (rst) out_valid |-> last)
    else $error("token without last");

  // tokens only carry defined classes
  a_type: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tok_class <= TOK_IDENTIFIER))
    else $error("undefined token class");

  // nothing is shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token valid after reset");

  // an empty lexer with no output backlog always takes input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(in_valid && in_ready) |-> in_ready)
    else $error("input refused while empty");

endmodule

bind keyword_token_lexer_unit kwl_checker u_kwl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .tok_class   (tokens.tok_class),
  .token_length(tokens.token_length),
  .last        (tokens.last)
);

// ===== tb/sv/tb_keyword_token_lexer_unit.sv =====
// tb_keyword_token_lexer_unit: self-checking bench that streams text and checks every token
`timescale 1ns / 1ps

module tb_keyword_token_lexer_unit;
  import kwl_pkg::*;

  localparam int PB            = POSITION_BITS_DEF;
  localparam int PFX           = PREFIX_CHARS_DEF;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1720;
  localparam int LONG_LEN      = 40;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 100;
  localparam int DRAIN_CYCLES  = 10;
  localparam int MAX_SHOWN     = 10;
  localparam longint RUN_LIMIT_NS = 100_000_000;

  // one character or end-of-line item, with an optional hand-written token
  typedef struct packed {
    logic        mode;
    logic [7:0]  ch;
    logic        typed;
    tok_type_t   kind;
    logic [15:0] line_idx;
    logic [15:0] col;
    logic [15:0] len;
  } lex_item_t;

  typedef struct {
    tok_type_t   kind;
    logic [15:0] line_idx;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kwl_in_if  chars ();
  kwl_out_if tokens ();

  keyword_token_lexer_unit #(
    .POSITION_BITS(PB),
    .PREFIX_CHARS (PFX)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .tokens(tokens)
  );

  always #6 clk = ~clk;

  lex_item_t stim_q[$];
  lex_item_t char_on_bus;
  tok_rec_t  tokens_due[$];
  tok_rec_t  new_tokens[$];
  int        err_count = 0;
  int        got_count = 0;

  // directed rows: keywords, marker tokens, byte extremes, slashes and comments
  lex_item_t dir_tab [0:24] = '{
    '{MODE_CHAR, "l",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, "e",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, "t",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, " ",      1'b1, TOK_LET,        16'd0, 16'd0,  16'd3},
    '{MODE_CHAR, "=",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, ">",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, 8'h0D,    1'b1, TOK_ARROW,      16'd0, 16'd4,  16'd2},
    '{MODE_CHAR, 8'hFF,    1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, 8'h00,    1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, CH_SLASH, 1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, 8'h09,    1'b1, TOK_IDENTIFIER, 16'd0, 16'd7,  16'd3},
    '{MODE_CHAR, "_",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, CH_SLASH, 1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, CH_SLASH, 1'b1, TOK_PARAM,      16'd0, 16'd11, 16'd1},
    '{MODE_CHAR, "q",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_EOL,  8'hFF,    1'b1, TOK_COMMENT,    16'd0, 16'd12, 16'd3},
    '{MODE_EOL,  8'h00,    1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, "*",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, CH_SLASH, 1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_EOL,  8'h00,    1'b1, TOK_IDENTIFIER, 16'd2, 16'd0,  16'd2},
    '{MODE_CHAR, "0",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, "x",      1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, CH_SLASH, 1'b0, TOK_IDENTIFIER, 16'd0, 16'd0,  16'd0},
    '{MODE_CHAR, CH_SLASH, 1'b1, TOK_HEX,        16'd3, 16'd0,  16'd2},
    '{MODE_EOL,  8'h55,    1'b1, TOK_COMMENT,    16'd3, 16'd2,  16'd2}
  };

  // lexer state as the predictor sees it
  bit [7:0]    pfx [PFX];
  bit [PB-1:0] tok_len;
  bit          slash_held;
  bit          in_cmt;
  bit [PB-1:0] cmt_start;
  bit [PB-1:0] line_pos;
  bit [PB-1:0] col_sum;
  bit [PB-1:0] line_no;

  function automatic bit [PB-1:0] sat_add(input bit [PB-1:0] a, input bit [PB-1:0] b);
    bit [PB:0] s;
    s = a + b;
    return s[PB] ? {PB{1'b1}} : s[PB-1:0];
  endfunction

  function automatic bit word_is(input string w);
    if (tok_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++)
      if (pfx[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic tok_type_t classify_token();
    if (word_is("let"))   return TOK_LET;
    if (word_is("def"))   return TOK_DEF;
    if (word_is("main"))  return TOK_MAIN;
    if (word_is("print")) return TOK_PRINT;
    if (word_is("=>"))    return TOK_ARROW;
    if (word_is("="))     return TOK_EQUALS;
    if (word_is("+"))     return TOK_PLUS;
    if (word_is("-"))     return TOK_MINUS;
    if (word_is("*"))     return TOK_MULTIPLY;
    if (tok_len >= 2 && pfx[0] == "0" && pfx[1] == "x") return TOK_HEX;
    if (tok_len >= 1 && pfx[0] == CH_UNDER) return TOK_PARAM;
    return TOK_IDENTIFIER;
  endfunction

  function automatic tok_rec_t make_rec(input tok_type_t kind, input bit [PB-1:0] col,
                                        input bit [PB-1:0] len);
    tok_rec_t r;
    r.kind     = kind;
    r.line_idx = line_no;
    r.col      = col;
    r.len      = len;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic void take_char(input bit [7:0] c);
    if (tok_len < PFX) pfx[tok_len] = c;
    tok_len = sat_add(tok_len, PB'(1));
  endfunction

  // close the current code token, if there is one
  function automatic void flush_code();
    if (tok_len == 0) return;
    new_tokens.insert(new_tokens.size(), make_rec(classify_token(), col_sum, tok_len));
    col_sum = sat_add(col_sum, sat_add(tok_len, PB'(1)));
    tok_len = '0;
    foreach (pfx[i]) pfx[i] = 8'h00;
  endfunction

  // advance the lexer by one item, leaving its tokens in new_tokens
  task automatic predict_tokens(input logic mode, input logic [7:0] c);
    bit [PB-1:0] pos;
    new_tokens.delete();
    if (mode == MODE_EOL) begin
      if (slash_held) take_char(CH_SLASH);
      flush_code();
      if (in_cmt)
        new_tokens.insert(new_tokens.size(),
                          make_rec(TOK_COMMENT, cmt_start,
                                   (line_pos >= cmt_start) ? line_pos - cmt_start : '0));
      tok_len    = '0;
      slash_held = 1'b0;
      in_cmt     = 1'b0;
      cmt_start  = '0;
      line_pos   = '0;
      col_sum    = '0;
      line_no    = sat_add(line_no, PB'(1));
    end else begin
      pos      = line_pos;
      line_pos = sat_add(line_pos, PB'(1));
      if (!in_cmt) begin
        if (slash_held && c == CH_SLASH) begin
          // second slash: code part ends here
          slash_held = 1'b0;
          in_cmt     = 1'b1;
          flush_code();
        end else begin
          if (slash_held) begin
            slash_held = 1'b0;
            take_char(CH_SLASH);
          end
          if (c == CH_SLASH) begin
            slash_held = 1'b1;
            cmt_start  = pos;
          end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            flush_code();
          end else begin
            take_char(c);
          end
        end
      end
    end
    if (new_tokens.size() > 0) new_tokens[new_tokens.size()-1].last = 1'b1;
  endtask

  // stimulus building
  task automatic add_item(input logic mode, input logic [7:0] c);
    lex_item_t it;
    it      = '0;
    it.mode = mode;
    it.ch   = c;
    it.kind = TOK_IDENTIFIER;
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(MODE_CHAR, s[i]);
  endtask

  task automatic add_blank();
    if ($urandom_range(0, 9) >= 4) add_item(MODE_CHAR, CH_SPACE);
    else add_item(MODE_CHAR, CH_TAB + 8'($urandom_range(0, 4)));
  endtask

  task automatic add_word();
    string hx;
    hx = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 14))
      0:  add_text("let");
      1:  add_text("def");
      2:  add_text("main");
      3:  add_text("print");
      4:  add_text("=>");
      5:  add_text("=");
      6:  add_text("+");
      7:  add_text("-");
      8:  add_text("*");
      9: begin
        add_text("0x");
        repeat ($urandom_range(0, 4)) add_item(MODE_CHAR, hx[$urandom_range(0, 21)]);
      end
      10: begin
        add_item(MODE_CHAR, CH_UNDER);
        repeat ($urandom_range(0, 7)) add_item(MODE_CHAR, "a" + 8'($urandom_range(0, 25)));
      end
      11: repeat ($urandom_range(1, 9)) add_item(MODE_CHAR, "a" + 8'($urandom_range(0, 25)));
      // near misses of the exact words, some longer than the kept prefix
      12: begin
        case ($urandom_range(0, 7))
          0: add_text("le");
          1: add_text("lets");
          2: add_text("=>=");
          3: add_text("0X1");
          4: add_text("++");
          5: add_text("printing");
          6: add_text("mainly");
          default: add_text("0");
        endcase
      end
      // a slash inside a token
      13: begin
        add_item(MODE_CHAR, "a" + 8'($urandom_range(0, 25)));
        add_item(MODE_CHAR, CH_SLASH);
        add_item(MODE_CHAR, "a" + 8'($urandom_range(0, 25)));
      end
      default: repeat ($urandom_range(1, 4))
        add_item(MODE_CHAR, 8'($urandom_range(8'h21, 8'hFF)));
    endcase
  endtask

  task automatic add_random_line();
    int shape;
    int n_words;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      add_item(MODE_EOL, 8'($urandom_range(0, 255)));
      return;
    end
    // noise: any bytes at all
    if (shape == 1) begin
      repeat ($urandom_range(1, 20)) add_item(MODE_CHAR, 8'($urandom_range(0, 255)));
      add_item(MODE_EOL, 8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) add_blank();
    n_words = $urandom_range(1, 6);
    for (int w = 0; w < n_words; w++) begin
      if (w > 0) repeat ($urandom_range(1, 2)) add_blank();
      add_word();
    end
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if ($urandom_range(0, 1) != 0) add_blank();
        add_text("//");
        repeat ($urandom_range(0, 10)) add_item(MODE_CHAR, 8'($urandom_range(0, 255)));
      end
      3: add_item(MODE_CHAR, CH_SLASH);
      4: add_blank();
      default: ;
    endcase
    add_item(MODE_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("ERROR: %s", msg);
  endtask

  // predict on every input transfer
  always @(posedge clk) begin : char_watch
    tok_rec_t r;
    if (!rst && chars.valid && chars.ready) begin
      predict_tokens(char_on_bus.mode, char_on_bus.ch);
      if (char_on_bus.typed) begin
        r.kind     = char_on_bus.kind;
        r.line_idx = char_on_bus.line_idx;
        r.col      = char_on_bus.col;
        r.len      = char_on_bus.len;
        r.last     = 1'b1;
        tokens_due.insert(tokens_due.size(), r);
      end else begin
        foreach (new_tokens[i]) tokens_due.insert(tokens_due.size(), new_tokens[i]);
      end
    end
  end

  // compare every token transfer with the oldest expectation
  always @(posedge clk) begin : token_check
    tok_rec_t want;
    if (!rst && tokens.valid && tokens.ready) begin
      got_count++;
      if (tokens_due.size() == 0) begin
        flag_error($sformatf("unexpected token: type %0d line %0d col %0d len %0d last %0b",
                             tokens.tok_class, tokens.line_index, tokens.column,
                             tokens.token_length, tokens.last));
      end else begin
        want = tokens_due.pop_front();
        if (tokens.tok_class !== want.kind || tokens.line_index !== want.line_idx ||
            tokens.column !== want.col || tokens.token_length !== want.len ||
            tokens.last !== want.last)
          flag_error($sformatf({"token %0d: expected type %0d line %0d col %0d len %0d last %0b,",
                                " got type %0d line %0d col %0d len %0d last %0b"},
                               got_count, want.kind, want.line_idx, want.col, want.len,
                               want.last, tokens.tok_class, tokens.line_index,
                               tokens.column, tokens.token_length, tokens.last));
      end
    end
  end

  // token receiver: changing stall patterns plus one long hold-off
  initial begin : token_sink
    int  pat;
    int  run;
    bit  held_once;
    tokens.ready = 1'b0;
    pat       = 0;
    run       = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && got_count >= HOLD_AFTER) begin
        held_once = 1'b1;
        tokens.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (run == 0) begin
          pat = $urandom_range(0, 3);
          run = $urandom_range(16, 200);
        end
        run--;
        case (pat)
          0: tokens.ready <= 1'b1;
          1: tokens.ready <= 1'($urandom_range(0, 1));
          2: tokens.ready <= ($urandom_range(0, 9) != 0);
          default: tokens.ready <= (run % 4 == 0);
        endcase
      end
    end
  end

  // build the stream, reset, then send it in bursts
  initial begin : char_source
    int base;
    int burst_left;
    int gap;
    chars.valid = 1'b0;
    chars.mode  = MODE_CHAR;
    chars.ch    = 8'h00;
    char_on_bus = '0;

    foreach (dir_tab[i]) stim_q.insert(stim_q.size(), dir_tab[i]);

    // one long line with a token far past the kept prefix
    add_text("ab ");
    repeat (LONG_LEN) add_item(MODE_CHAR, 8'($urandom_range(8'h21, 8'h2E)));
    add_text(" let //c");
    add_item(MODE_EOL, 8'h00);

    base = stim_q.size();
    while (stim_q.size() - base < RANDOM_ITEMS) add_random_line();

    // one more line of code with a comment to close the stream
    add_text("x y //z");
    add_item(MODE_EOL, 8'h00);

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    burst_left = 0;
    while (stim_q.size() > 0) begin
      @(negedge clk);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          chars.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      char_on_bus = stim_q.pop_front();
      chars.valid <= 1'b1;
      chars.mode  <= char_on_bus.mode;
      chars.ch    <= char_on_bus.ch;
      burst_left--;
      @(posedge clk);
      while (!chars.ready) @(posedge clk);
    end
    @(negedge clk);
    chars.valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("timeout with %0d tokens outstanding", tokens_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/kwl_pkg.sv
sv/kwl_if.sv
sv/kwl_classify.sv
sv/keyword_token_lexer_unit.sv
sv/kwl_checker.sv
tb/sv/tb_keyword_token_lexer_unit.sv
